>>> rtl/mafs_pkg.sv
// mafs_pkg: shared types, tables and header decode functions for the
// mpeg audio frame sync block; no dependencies
package mafs_pkg;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        frame_start;
    logic        frame_last;
    logic [1:0]  layer_num;
    logic [1:0]  version_code;
    logic [15:0] sample_rate_hz;
    logic [8:0]  bit_rate_kbps;
    logic [11:0] frame_bytes;
    logic [1:0]  channel_count;
    logic        crc_present;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
  } mafs_beat_t;

  localparam logic [31:0] SYNC_MASK  = 32'hffe0_0000;
  localparam logic [3:0]  BR_FREE    = 4'h0;
  localparam logic [3:0]  BR_BAD     = 4'hf;
  localparam logic [1:0]  SR_RSVD    = 2'd3;
  localparam logic [1:0]  LAYER_RSVD = 2'd0;
  localparam logic [1:0]  MODE_MONO  = 2'd3;
  localparam logic [1:0]  LAYER_ONE  = 2'd1;
  localparam logic [1:0]  LAYER_TWO  = 2'd2;
  localparam logic [1:0]  VER_MPEG1  = 2'd0;
  localparam logic [1:0]  VER_LSF    = 2'd1;
  localparam logic [1:0]  VER_MPEG25 = 2'd2;
  localparam logic [17:0] L1_SCALE   = 18'd12000;
  localparam logic [17:0] L23_SCALE  = 18'd144000;

  localparam logic [15:0] BASE_RATE [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd32000};

  localparam logic [8:0] KBPS_TBL [2][3][16] = '{
    '{'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}},
    '{'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}}
  };

  function automatic logic header_ok(input logic [31:0] h);
    return ((h & SYNC_MASK) == SYNC_MASK) && (h[18:17] != LAYER_RSVD) &&
           (h[15:12] != BR_FREE) && (h[15:12] != BR_BAD) && (h[11:10] != SR_RSVD);
  endfunction

  function automatic logic [1:0] version_of(input logic [31:0] h);
    if (h[20]) begin
      return h[19] ? VER_MPEG1 : VER_LSF;
    end
    return VER_MPEG25;
  endfunction

  // 4 minus layer bits, modulo 4
  function automatic logic [1:0] layer_of(input logic [31:0] h);
    return 2'd0 - h[18:17];
  endfunction

  function automatic logic [15:0] rate_of(input logic [31:0] h);
    return BASE_RATE[h[11:10]] >> version_of(h);
  endfunction

  function automatic logic [8:0] kbps_of(input logic [31:0] h);
    logic       lowrate;
    logic [1:0] lidx;
    lowrate = (version_of(h) != VER_MPEG1);
    lidx    = layer_of(h) - 2'd1;
    return KBPS_TBL[lowrate][lidx][h[15:12]];
  endfunction

  function automatic mafs_beat_t beat_of(input logic [31:0] h, input logic [11:0] len,
                                         input logic [7:0] b, input logic start,
                                         input logic last);
    mafs_beat_t r;
    r.out_byte       = b;
    r.frame_start    = start;
    r.frame_last     = last;
    r.layer_num      = layer_of(h);
    r.version_code   = version_of(h);
    r.sample_rate_hz = rate_of(h);
    r.bit_rate_kbps  = kbps_of(h);
    r.frame_bytes    = len;
    r.channel_count  = (h[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
    r.crc_present    = ~h[16];
    r.channel_mode   = h[7:6];
    r.mode_extension = h[5:4];
    return r;
  endfunction

endpackage

>>> rtl/mafs_if.sv
// mafs_if: valid/ready stream interfaces for the input bytes and the
// output frame beats; no dependencies
interface mafs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface mafs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        frame_start;
  logic        frame_last;
  logic [1:0]  layer_num;
  logic [1:0]  version_code;
  logic [15:0] sample_rate_hz;
  logic [8:0]  bit_rate_kbps;
  logic [11:0] frame_bytes;
  logic [1:0]  channel_count;
  logic        crc_present;
  logic [1:0]  channel_mode;
  logic [1:0]  mode_extension;
  modport source (output valid, input ready, output out_byte, output frame_start,
                  output frame_last, output layer_num, output version_code,
                  output sample_rate_hz, output bit_rate_kbps, output frame_bytes,
                  output channel_count, output crc_present, output channel_mode,
                  output mode_extension);
  modport sink (input valid, output ready, input out_byte, input frame_start,
                input frame_last, input layer_num, input version_code,
                input sample_rate_hz, input bit_rate_kbps, input frame_bytes,
                input channel_count, input crc_present, input channel_mode,
                input mode_extension);
endinterface

>>> rtl/mpeg_audio_frame_sync.sv
// mpeg_audio_frame_sync: header search, frame length by a restoring
// divider, frame slicing; uses mafs_pkg and mafs_if
//
//   channel | dir | modport | payload
//   in_i    | in  | sink    | stream_byte, one per beat
//   out_o   | out | source  | frame byte plus decoded header fields
//
// search: one byte per cycle, no output beat
// valid header: a multiply state, then 12 divider steps, then 4 header beats
// frame bytes: one per cycle while the output register drains
// reset clears the sequencer, window fill and output valid
// in_i.ready is low during the multiply, while the divider runs, header beats are pending
// or a frame beat waits on out_o.ready
module mpeg_audio_frame_sync import mafs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mafs_in_if.sink    in_i,
  mafs_out_if.source out_o
);

  localparam logic [2:0] ST_SEARCH = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_HDR    = 3'd3;
  localparam logic [2:0] ST_FRAME  = 3'd4;
  localparam logic [3:0] DIV_LAST  = 4'd11;

  logic [2:0]  state_q, state_d;
  logic [23:0] win_q, win_d;
  logic [1:0]  fill_q, fill_d;
  logic [31:0] hdr_q, hdr_d;
  logic [11:0] len_q, len_d;
  logic [11:0] seen_q, seen_d;
  logic [15:0] div_q, div_d;
  logic [15:0] rem_q, rem_d;
  logic [11:0] quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  mafs_beat_t  out_q, out_d;

  logic        in_ready;
  logic        in_fire;
  logic        out_free;
  logic [31:0] cand;
  logic [26:0] product;
  logic [15:0] rate_h;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;
  logic [11:0] qpad;
  logic [11:0] seen_inc;
  logic [7:0]  hdr_byte;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_ready = (state_q == ST_SEARCH) || ((state_q == ST_FRAME) && out_free);
  assign in_fire  = in_i.valid && in_ready;
  assign cand     = {win_q, in_i.stream_byte};
  assign product  = kbps_of(hdr_q) * ((layer_of(hdr_q) == LAYER_ONE) ? L1_SCALE : L23_SCALE);
  assign rate_h   = rate_of(hdr_q);
  assign trial    = {rem_q, quo_q[11]};
  assign diff     = trial - {1'b0, div_q};
  assign ge       = trial >= {1'b0, div_q};
  assign seen_inc = seen_q + 12'd1;

  always_comb begin
    case (idx_q)
      2'd0:    hdr_byte = hdr_q[31:24];
      2'd1:    hdr_byte = hdr_q[23:16];
      2'd2:    hdr_byte = hdr_q[15:8];
      default: hdr_byte = hdr_q[7:0];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    fill_d      = fill_q;
    hdr_d       = hdr_q;
    len_d       = len_q;
    seen_d      = seen_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    qpad        = '0;
    case (state_q)
      ST_SEARCH: begin
        if (in_fire) begin
          if (fill_q != 2'd3) begin
            win_d  = cand[23:0];
            fill_d = fill_q + 2'd1;
          end else if (header_ok(cand)) begin
            hdr_d   = cand;
            win_d   = '0;
            fill_d  = '0;
            state_d = ST_MUL;
          end else begin
            win_d = cand[23:0];
          end
        end
      end
      ST_MUL: begin
        rem_d = {2'b00, product[25:12]};
        quo_d = product[11:0];
        if ((layer_of(hdr_q) != LAYER_ONE) && (layer_of(hdr_q) != LAYER_TWO) &&
            (version_of(hdr_q) != VER_MPEG1)) begin
          div_d = {rate_h[14:0], 1'b0};
        end else begin
          div_d = rate_h;
        end
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? diff[15:0] : trial[15:0];
        quo_d = {quo_q[10:0], ge};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == DIV_LAST) begin
          qpad = quo_d + {11'd0, hdr_q[9]};
          len_d   = (layer_of(hdr_q) == LAYER_ONE) ? {qpad[9:0], 2'b00} : qpad;
          idx_d   = '0;
          state_d = ST_HDR;
        end
      end
      ST_HDR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = beat_of(hdr_q, len_q, hdr_byte, idx_q == 2'd0, 1'b0);
          idx_d       = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            seen_d  = 12'd4;
            state_d = ST_FRAME;
          end
        end
      end
      ST_FRAME: begin
        if (in_fire) begin
          out_valid_d = 1'b1;
          out_d       = beat_of(hdr_q, len_q, in_i.stream_byte, 1'b0, seen_inc >= len_q);
          seen_d      = seen_inc;
          if (seen_inc >= len_q) begin
            seen_d  = '0;
            win_d   = '0;
            fill_d  = '0;
            state_d = ST_SEARCH;
          end
        end
      end
      default: begin
        state_d = ST_SEARCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEARCH;
      win_q       <= '0;
      fill_q      <= '0;
      seen_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      fill_q      <= fill_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    len_q <= len_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    out_q <= out_d;
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_q.out_byte;
  assign out_o.frame_start    = out_q.frame_start;
  assign out_o.frame_last     = out_q.frame_last;
  assign out_o.layer_num      = out_q.layer_num;
  assign out_o.version_code   = out_q.version_code;
  assign out_o.sample_rate_hz = out_q.sample_rate_hz;
  assign out_o.bit_rate_kbps  = out_q.bit_rate_kbps;
  assign out_o.frame_bytes    = out_q.frame_bytes;
  assign out_o.channel_count  = out_q.channel_count;
  assign out_o.crc_present    = out_q.crc_present;
  assign out_o.channel_mode   = out_q.channel_mode;
  assign out_o.mode_extension = out_q.mode_extension;

endmodule

>>> rtl/mafs_checker.sv
// mafs_checker: port-level checks on the frame sync output beats,
// bound to mpeg_audio_frame_sync; no package dependency
module mafs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_i,
  input logic        frame_start_i,
  input logic        frame_last_i,
  input logic [11:0] frame_bytes_i
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i))
    else $error("output beat changed while stalled");

  // a frame never starts and ends on the same beat
  a_start_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(frame_start_i && frame_last_i))
    else $error("frame start and last on one beat");

  // decoded frame length within the legal range
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (frame_bytes_i >= 12'd24) && (frame_bytes_i <= 12'd2881))
    else $error("frame length out of range");

endmodule

bind mpeg_audio_frame_sync mafs_checker u_mafs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .frame_start_i (out_o.frame_start),
  .frame_last_i  (out_o.frame_last),
  .frame_bytes_i (out_o.frame_bytes)
);

>>> tb/tb_mpeg_audio_frame_sync.sv
`timescale 1ns / 1ps
// tb_mpeg_audio_frame_sync: drives an mpeg audio byte stream into the frame
// sync block and checks every output beat against a header-decoding scoreboard;
// uses mafs_pkg, mafs_if and mpeg_audio_frame_sync
module tb_mpeg_audio_frame_sync;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_BYTES  = 60;
  localparam int DRAIN_CYCLES = 40;

  localparam int KBPS_TABLE [2][3][16] = '{
    '{'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}},
    '{'{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}}
  };

  class frame_slicer_sb;
    mafs_pkg::mafs_beat_t pending_beats[$];
    logic [23:0] win;
    int          fill;
    bit          in_frame;
    logic [31:0] hdr;
    logic [11:0] flen;
    logic [11:0] seen;
    int          errors;
    int          bytes_in;
    int          beats_out;
    int          frames_out;

    function new();
      win = '0;
      fill = 0;
      in_frame = 0;
      hdr = '0;
      flen = '0;
      seen = '0;
      errors = 0;
      bytes_in = 0;
      beats_out = 0;
      frames_out = 0;
    endfunction

    function bit hdr_valid(logic [31:0] h);
      if (h[31:21] != 11'h7ff) return 0;
      if (h[18:17] == mafs_pkg::LAYER_RSVD) return 0;
      if (h[15:12] == mafs_pkg::BR_FREE || h[15:12] == mafs_pkg::BR_BAD) return 0;
      if (h[11:10] == mafs_pkg::SR_RSVD) return 0;
      return 1;
    endfunction

    function logic [1:0] ver_code(logic [31:0] h);
      if (!h[20]) return mafs_pkg::VER_MPEG25;
      return h[19] ? mafs_pkg::VER_MPEG1 : mafs_pkg::VER_LSF;
    endfunction

    function int layer_val(logic [31:0] h);
      return 4 - int'(h[18:17]);
    endfunction

    function int rate_hz(logic [31:0] h);
      int base;
      case (h[11:10])
        2'd0: base = 44100;
        2'd1: base = 48000;
        default: base = 32000;
      endcase
      return base >> ver_code(h);
    endfunction

    function int kbps(logic [31:0] h);
      int lsf;
      lsf = (ver_code(h) != mafs_pkg::VER_MPEG1) ? 1 : 0;
      return KBPS_TABLE[lsf][layer_val(h) - 1][h[15:12]];
    endfunction

    function logic [11:0] frame_len(logic [31:0] h);
      int r;
      int k;
      int pad;
      int lsf;
      int len;
      r = rate_hz(h);
      k = kbps(h);
      pad = int'(h[9]);
      lsf = (ver_code(h) != mafs_pkg::VER_MPEG1) ? 1 : 0;
      case (layer_val(h))
        1: len = ((k * 12000) / r + pad) * 4;
        2: len = (k * 144000) / r + pad;
        default: len = (k * 144000) / (r << lsf) + pad;
      endcase
      return len[11:0];
    endfunction

    function mafs_pkg::mafs_beat_t make_beat(logic [7:0] b, logic start, logic last);
      mafs_pkg::mafs_beat_t e;
      e.out_byte       = b;
      e.frame_start    = start;
      e.frame_last     = last;
      e.layer_num      = 2'(layer_val(hdr));
      e.version_code   = ver_code(hdr);
      e.sample_rate_hz = 16'(rate_hz(hdr));
      e.bit_rate_kbps  = 9'(kbps(hdr));
      e.frame_bytes    = flen;
      e.channel_count  = (hdr[7:6] == mafs_pkg::MODE_MONO) ? 2'd1 : 2'd2;
      e.crc_present    = ~hdr[16];
      e.channel_mode   = hdr[7:6];
      e.mode_extension = hdr[5:4];
      return e;
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction

    task take_byte(logic [7:0] b);
      logic [31:0] h;
      logic        last;
      bytes_in++;
      if (in_frame) begin
        seen = seen + 12'd1;
        last = (seen >= flen);
        pending_beats.push_back(make_beat(b, 1'b0, last));
        if (last) begin
          in_frame = 0;
          fill = 0;
          win = '0;
          seen = '0;
        end
        return;
      end
      if (fill < 3) begin
        win = {win[15:0], b};
        fill++;
        return;
      end
      h = {win, b};
      if (!hdr_valid(h)) begin
        win = h[23:0];
        return;
      end
      hdr = h;
      flen = frame_len(h);
      in_frame = 1;
      win = '0;
      fill = 0;
      seen = 12'd4;
      for (int k = 0; k < 4; k++) begin
        pending_beats.push_back(make_beat(h[31 - 8 * k -: 8], k == 0, 1'b0));
      end
    endtask

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task cmp(string name, int got, int want);
      if (got != want) begin
        report($sformatf("beat %0d %s got %0d want %0d", beats_out, name, got, want));
      end
    endtask

    task match_beat(mafs_pkg::mafs_beat_t got);
      mafs_pkg::mafs_beat_t e;
      if (pending_beats.size() == 0) begin
        report($sformatf("beat %0d unexpected, byte %02h", beats_out, got.out_byte));
        beats_out++;
        return;
      end
      e = pending_beats.pop_front();
      cmp("out_byte", got.out_byte, e.out_byte);
      cmp("frame_start", got.frame_start, e.frame_start);
      cmp("frame_last", got.frame_last, e.frame_last);
      cmp("layer_num", got.layer_num, e.layer_num);
      cmp("version_code", got.version_code, e.version_code);
      cmp("sample_rate_hz", got.sample_rate_hz, e.sample_rate_hz);
      cmp("bit_rate_kbps", got.bit_rate_kbps, e.bit_rate_kbps);
      cmp("frame_bytes", got.frame_bytes, e.frame_bytes);
      cmp("channel_count", got.channel_count, e.channel_count);
      cmp("crc_present", got.crc_present, e.crc_present);
      cmp("channel_mode", got.channel_mode, e.channel_mode);
      cmp("mode_extension", got.mode_extension, e.mode_extension);
      if (e.frame_start) frames_out++;
      beats_out++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycles;
  bit   no_gaps;
  frame_slicer_sb sb;

  mafs_in_if  in_if ();
  mafs_out_if out_if ();

  mpeg_audio_frame_sync dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.stream_byte = 8'h00;
    out_if.ready = 1'b0;
    cycles = 0;
    no_gaps = 0;
    sb = new();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // output side: random stalls, compare accepted beats
  always @(posedge clk_i) begin
    mafs_pkg::mafs_beat_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.out_byte       = out_if.out_byte;
        got.frame_start    = out_if.frame_start;
        got.frame_last     = out_if.frame_last;
        got.layer_num      = out_if.layer_num;
        got.version_code   = out_if.version_code;
        got.sample_rate_hz = out_if.sample_rate_hz;
        got.bit_rate_kbps  = out_if.bit_rate_kbps;
        got.frame_bytes    = out_if.frame_bytes;
        got.channel_count  = out_if.channel_count;
        got.crc_present    = out_if.crc_present;
        got.channel_mode   = out_if.channel_mode;
        got.mode_extension = out_if.mode_extension;
        sb.match_beat(got);
      end
      out_if.ready <= no_gaps || ($urandom_range(99) >= 24);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!no_gaps && $urandom_range(99) < 24) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.stream_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.take_byte(b);
  endtask

  task automatic send_header(input logic [31:0] h);
    for (int k = 0; k < 4; k++) send_byte(h[31 - 8 * k -: 8]);
  endtask

  task automatic send_body(input int n);
    for (int k = 0; k < n; k++) send_byte(8'($urandom));
  endtask

  // ver bits, layer bits, br index, sr code, padding; rest of the header random
  function automatic logic [31:0] build_header(input logic [1:0] ver, input logic [1:0] lay,
                                               input logic [3:0] br, input logic [1:0] sr,
                                               input logic pad);
    logic [31:0] h;
    h = $urandom;
    h[31:21] = 11'h7ff;
    h[20:19] = ver;
    h[18:17] = lay;
    h[15:12] = br;
    h[11:10] = sr;
    h[9] = pad;
    return h;
  endfunction

  function automatic logic [31:0] rand_header();
    return build_header(2'($urandom_range(3)), 2'($urandom_range(3, 1)),
                        4'($urandom_range(14, 1)), 2'($urandom_range(2)),
                        1'($urandom_range(1)));
  endfunction

  function automatic logic [31:0] short_header(input int cap);
    logic [31:0] h;
    h = rand_header();
    while (int'(sb.frame_len(h)) > cap) h = rand_header();
    return h;
  endfunction

  function automatic logic [31:0] broken_header();
    logic [31:0] h;
    h = rand_header();
    case ($urandom_range(4))
      0: h[21 + $urandom_range(10)] = 1'b0;
      1: h[18:17] = mafs_pkg::LAYER_RSVD;
      2: h[15:12] = mafs_pkg::BR_FREE;
      3: h[15:12] = mafs_pkg::BR_BAD;
      default: h[11:10] = mafs_pkg::SR_RSVD;
    endcase
    return h;
  endfunction

  initial begin
    logic [31:0] h;
    int          n;
    int          start_bytes;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window still filling
    send_byte(8'h00);
    send_byte(8'h7f);
    // rejected headers: broken sync, reserved layer, free format, bad index, reserved rate
    send_header({8'hff, 8'hc2, 8'h14, 8'h00});
    send_header({8'hff, 8'hf9, 8'h14, 8'h00});
    send_header({8'hff, 8'hfb, 8'h04, 8'h00});
    send_header({8'hff, 8'hfb, 8'hf4, 8'h00});
    send_header({8'hff, 8'hfb, 8'h1c, 8'h00});
    // reserved version bits treated as mpeg-2.5
    h = build_header(2'b01, 2'b01, 4'd1, 2'd1, 1'b0);
    send_header(h);
    send_body(int'(sb.frame_len(h)) - 4);
    // shortest frame: mpeg-2 layer 3
    h = build_header(2'b10, 2'b01, 4'd1, 2'd1, 1'b0);
    send_header(h);
    send_body(int'(sb.frame_len(h)) - 4);
    // layer 1 slot rounding with padding
    h = build_header(2'b11, 2'b11, 4'd1, 2'd1, 1'b1);
    send_header(h);
    send_body(int'(sb.frame_len(h)) - 4);

    start_bytes = sb.bytes_in;
    while (sb.bytes_in - start_bytes < RAND_BYTES) begin
      no_gaps = (sb.bytes_in - start_bytes >= 15) && (sb.bytes_in - start_bytes < 45);
      n = $urandom_range(99);
      if (n < 78) begin
        repeat ($urandom_range(99) < 20 ? $urandom_range(3, 1) : 0) send_byte(8'($urandom));
        h = short_header(($urandom_range(7) == 0) ? 200 : 64);
        send_header(h);
        n = int'(sb.frame_len(h)) - 4;
        if ($urandom_range(9) == 0) n = $urandom_range(n);
        send_body(n);
      end else if (n < 90) begin
        send_header(broken_header());
      end else begin
        send_body($urandom_range(6, 1));
      end
    end
    no_gaps = 0;

    // close any frame left open so the next header is searched
    while (sb.in_frame) send_byte(8'($urandom));

    // longest frame header: mpeg-2.5 layer 2, top index, lowest rate, padded
    h = build_header(2'b00, 2'b10, 4'd14, 2'd2, 1'b1);
    send_header(h);
    send_body(4);

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d input bytes, %0d output beats, %0d frames", sb.bytes_in,
             sb.beats_out, sb.frames_out);
    $display("includes rejected headers, reserved version, shortest and longest frames");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> mpeg_audio_frame_sync.f
rtl/mafs_pkg.sv
rtl/mafs_if.sv
rtl/mpeg_audio_frame_sync.sv
rtl/mafs_checker.sv
tb/tb_mpeg_audio_frame_sync.sv
